FILE: src/s2sd_pkg.sv
// Shared constants and width helpers for the segment distance pipeline.
package s2sd_pkg;

    // Default coordinate width and result width
    localparam int COORD_BITS_DEF = 24;
    localparam int OUT_W          = 32;

    // Divisor width: squared segment length of COORD_BITS coordinates
    function automatic int f_den_w(input int coord_bits);
        return 2 * coord_bits + 2;
    endfunction

    // Quotient width: four times the largest squared distance
    function automatic int f_quo_w(input int coord_bits);
        return 2 * coord_bits + 4;
    endfunction

    // Integer square root width of the quotient
    function automatic int f_sqrt_w(input int coord_bits);
        return coord_bits + 2;
    endfunction

endpackage

FILE: src/segment_to_segment_distance_2d.sv
// Top level: minimum distance between two 2D segments, fully pipelined.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-----------------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_seg_{a,b}_{start,end}_{x,y}
//  out     | output    | o_out_valid / i_out_ready  | o_min_distance
//
// One pair per cycle sustained while the output register is not waiting. The pipeline
// holds the product stages, a bit-per-stage divider and a bit-per-stage square root.
// Reset (synchronous, active low) clears the valid bits and the input skid valid flag.
// The whole pipeline holds while the output register waits; a skid register at the
// input still takes one transfer during that hold.
module segment_to_segment_distance_2d #(
    parameter int COORD_BITS = s2sd_pkg::COORD_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [COORD_BITS-1:0]         i_seg_a_start_x,
    input  logic signed [COORD_BITS-1:0]         i_seg_a_start_y,
    input  logic signed [COORD_BITS-1:0]         i_seg_a_end_x,
    input  logic signed [COORD_BITS-1:0]         i_seg_a_end_y,
    input  logic signed [COORD_BITS-1:0]         i_seg_b_start_x,
    input  logic signed [COORD_BITS-1:0]         i_seg_b_start_y,
    input  logic signed [COORD_BITS-1:0]         i_seg_b_end_x,
    input  logic signed [COORD_BITS-1:0]         i_seg_b_end_y,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [s2sd_pkg::OUT_W-1:0]           o_min_distance
);
    import s2sd_pkg::*;

    localparam int C      = COORD_BITS;
    localparam int DW     = C + 1;
    localparam int PW     = 2 * DW;
    localparam int SUMW   = PW + 1;
    localparam int CAW    = f_den_w(C);
    localparam int HW     = CAW / 2;
    localparam int NW     = 2 * CAW;
    localparam int QW     = f_quo_w(C);
    localparam int SW     = f_sqrt_w(C);
    localparam int NUMW   = CAW + QW;
    localparam int LAT    = 9 + QW + SW;

    // Input skid register and pipeline enable
    logic                r_skid_vld;
    logic [C-1:0]        r_skid_pt [8];
    logic [C-1:0]        w_in_pt   [8];
    logic [C-1:0]        w_src_pt  [8];
    logic                w_src_vld;
    logic                w_ce;
    logic [LAT-1:0]      r_vld;

    assign w_in_pt[0] = i_seg_a_start_x;
    assign w_in_pt[1] = i_seg_a_start_y;
    assign w_in_pt[2] = i_seg_a_end_x;
    assign w_in_pt[3] = i_seg_a_end_y;
    assign w_in_pt[4] = i_seg_b_start_x;
    assign w_in_pt[5] = i_seg_b_start_y;
    assign w_in_pt[6] = i_seg_b_end_x;
    assign w_in_pt[7] = i_seg_b_end_y;

    assign o_in_ready = ~r_skid_vld;
    assign w_ce       = ~r_vld[LAT-1] | i_out_ready;
    assign w_src_vld  = r_skid_vld | i_in_valid;

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            w_src_pt[k] = r_skid_vld ? r_skid_pt[k] : w_in_pt[k];
        end
    end

    // Capture a transfer in the skid register while the pipeline holds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_vld <= 1'b0;
        end else if (w_ce) begin
            r_skid_vld <= 1'b0;
        end else if (i_in_valid && !r_skid_vld) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_ce && i_in_valid && !r_skid_vld) begin
            r_skid_pt <= w_in_pt;
        end
    end

    // Advance valid bits alongside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_ce) begin
            r_vld <= {r_vld[LAT-2:0], w_src_vld};
        end
    end

    // Sign-extend coordinates for differences
    logic signed [DW-1:0] w_a1x, w_a1y, w_a2x, w_a2y, w_b1x, w_b1y, w_b2x, w_b2y;
    assign w_a1x = {w_src_pt[0][C-1], w_src_pt[0]};
    assign w_a1y = {w_src_pt[1][C-1], w_src_pt[1]};
    assign w_a2x = {w_src_pt[2][C-1], w_src_pt[2]};
    assign w_a2y = {w_src_pt[3][C-1], w_src_pt[3]};
    assign w_b1x = {w_src_pt[4][C-1], w_src_pt[4]};
    assign w_b1y = {w_src_pt[5][C-1], w_src_pt[5]};
    assign w_b2x = {w_src_pt[6][C-1], w_src_pt[6]};
    assign w_b2y = {w_src_pt[7][C-1], w_src_pt[7]};

    // Stage 1: per lane segment vector, start-to-point and end-to-point vectors
    logic signed [DW-1:0] r1_abx [4], r1_aby [4];
    logic signed [DW-1:0] r1_apx [4], r1_apy [4];
    logic signed [DW-1:0] r1_qx  [4], r1_qy  [4];

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            // first start point against second segment
            r1_abx[0] <= w_b2x - w_b1x;  r1_aby[0] <= w_b2y - w_b1y;
            r1_apx[0] <= w_a1x - w_b1x;  r1_apy[0] <= w_a1y - w_b1y;
            r1_qx[0]  <= w_a1x - w_b2x;  r1_qy[0]  <= w_a1y - w_b2y;
            // first end point against second segment
            r1_abx[1] <= w_b2x - w_b1x;  r1_aby[1] <= w_b2y - w_b1y;
            r1_apx[1] <= w_a2x - w_b1x;  r1_apy[1] <= w_a2y - w_b1y;
            r1_qx[1]  <= w_a2x - w_b2x;  r1_qy[1]  <= w_a2y - w_b2y;
            // second start point against first segment
            r1_abx[2] <= w_a2x - w_a1x;  r1_aby[2] <= w_a2y - w_a1y;
            r1_apx[2] <= w_b1x - w_a1x;  r1_apy[2] <= w_b1y - w_a1y;
            r1_qx[2]  <= w_b1x - w_a2x;  r1_qy[2]  <= w_b1y - w_a2y;
            // second end point against first segment
            r1_abx[3] <= w_a2x - w_a1x;  r1_aby[3] <= w_a2y - w_a1y;
            r1_apx[3] <= w_b2x - w_a1x;  r1_apy[3] <= w_b2y - w_a1y;
            r1_qx[3]  <= w_b2x - w_a2x;  r1_qy[3]  <= w_b2y - w_a2y;
        end
    end

    // Stage 2: products
    logic signed [PW-1:0] r2_abab_x [4], r2_abab_y [4];
    logic signed [PW-1:0] r2_apab_x [4], r2_apab_y [4];
    logic signed [PW-1:0] r2_apap_x [4], r2_apap_y [4];
    logic signed [PW-1:0] r2_qq_x   [4], r2_qq_y   [4];
    logic signed [PW-1:0] r2_cr_p   [4], r2_cr_n   [4];

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            for (int k = 0; k < 4; k++) begin
                r2_abab_x[k] <= r1_abx[k] * r1_abx[k];
                r2_abab_y[k] <= r1_aby[k] * r1_aby[k];
                r2_apab_x[k] <= r1_apx[k] * r1_abx[k];
                r2_apab_y[k] <= r1_apy[k] * r1_aby[k];
                r2_apap_x[k] <= r1_apx[k] * r1_apx[k];
                r2_apap_y[k] <= r1_apy[k] * r1_apy[k];
                r2_qq_x[k]   <= r1_qx[k] * r1_qx[k];
                r2_qq_y[k]   <= r1_qy[k] * r1_qy[k];
                r2_cr_p[k]   <= r1_abx[k] * r1_apy[k];
                r2_cr_n[k]   <= r1_aby[k] * r1_apx[k];
            end
        end
    end

    // Stage 3: dot products and cross products
    logic signed [SUMW-1:0] r3_ab2 [4], r3_t [4], r3_ap2 [4], r3_q2 [4], r3_c [4];

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            for (int k = 0; k < 4; k++) begin
                r3_ab2[k] <= SUMW'(r2_abab_x[k]) + SUMW'(r2_abab_y[k]);
                r3_t[k]   <= SUMW'(r2_apab_x[k]) + SUMW'(r2_apab_y[k]);
                r3_ap2[k] <= SUMW'(r2_apap_x[k]) + SUMW'(r2_apap_y[k]);
                r3_q2[k]  <= SUMW'(r2_qq_x[k])   + SUMW'(r2_qq_y[k]);
                r3_c[k]   <= SUMW'(r2_cr_p[k])   - SUMW'(r2_cr_n[k]);
            end
        end
    end

    // Stage 4: pick the closest-point case, form the crossing flag
    logic                 r4_perp [4];
    logic [CAW-1:0]       r4_nend [4];
    logic [CAW-1:0]       r4_cabs [4];
    logic [CAW-1:0]       r4_den  [4];
    logic                 r4_x;
    logic                 w_cpos [4];
    logic                 w_cneg [4];
    logic                 w_cross;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_cneg[k] = r3_c[k][SUMW-1];
            w_cpos[k] = ~r3_c[k][SUMW-1] & (r3_c[k] != '0);
        end
        w_cross = ((w_cneg[2] & w_cpos[3]) | (w_cpos[2] & w_cneg[3]))
                & ((w_cneg[0] & w_cpos[1]) | (w_cpos[0] & w_cneg[1]));
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            for (int k = 0; k < 4; k++) begin
                logic t_le0;
                logic t_ge;
                logic [SUMW-1:0] cabs;
                t_le0 = r3_t[k][SUMW-1] | (r3_t[k] == '0);
                t_ge  = (r3_t[k] >= r3_ab2[k]);
                cabs  = r3_c[k][SUMW-1] ? SUMW'(-r3_c[k]) : SUMW'(r3_c[k]);
                r4_perp[k] <= ~t_le0 & ~t_ge;
                r4_nend[k] <= t_le0 ? r3_ap2[k][CAW-1:0] : r3_q2[k][CAW-1:0];
                r4_cabs[k] <= cabs[CAW-1:0];
                r4_den[k]  <= (~t_le0 & ~t_ge) ? r3_ab2[k][CAW-1:0] : CAW'(1);
            end
            r4_x <= w_cross;
        end
    end

    // Stage 5: square the cross product in halves
    logic             r5_perp [4];
    logic [CAW-1:0]   r5_nend [4];
    logic [CAW-1:0]   r5_den  [4];
    logic [2*HW-1:0]  r5_hh [4], r5_hl [4], r5_ll [4];
    logic             r5_x;

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            for (int k = 0; k < 4; k++) begin
                r5_hh[k]   <= r4_cabs[k][CAW-1:HW] * r4_cabs[k][CAW-1:HW];
                r5_hl[k]   <= r4_cabs[k][CAW-1:HW] * r4_cabs[k][HW-1:0];
                r5_ll[k]   <= r4_cabs[k][HW-1:0]   * r4_cabs[k][HW-1:0];
                r5_perp[k] <= r4_perp[k];
                r5_nend[k] <= r4_nend[k];
                r5_den[k]  <= r4_den[k];
            end
            r5_x <= r4_x;
        end
    end

    // Stage 6: numerator times four and divisor for each lane
    logic [NUMW-1:0] r6_num [4];
    logic [CAW-1:0]  r6_den [4];
    logic            r6_x;

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            for (int k = 0; k < 4; k++) begin
                logic [NW-1:0] csq;
                csq = {r5_hh[k], {(2*HW){1'b0}}}
                    + (NW'(r5_hl[k]) << (HW + 1))
                    + NW'(r5_ll[k]);
                r6_num[k] <= r5_perp[k] ? {csq, 2'b00} : {NW'(r5_nend[k]), 2'b00};
                r6_den[k] <= r5_den[k];
            end
            r6_x <= r5_x;
        end
    end

    // Dividers: floor(4 n / d) for each lane
    logic [QW-1:0] w_quo [4];

    genvar g;
    generate
        for (g = 0; g < 4; g++) begin : g_lane
            s2sd_div #(
                .COORD_BITS (COORD_BITS)
            ) u_div (
                .i_clk (i_clk),
                .i_ce  (w_ce),
                .i_num (r6_num[g]),
                .i_den (r6_den[g]),
                .o_quo (w_quo[g])
            );
        end
    endgenerate

    // Delay the crossing flag across the dividers
    logic [QW-1:0] r_xd;

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_xd <= {r_xd[QW-2:0], r6_x};
        end
    end

    // Min tree, then force zero for crossing segments
    logic [QW-1:0] r7_m01, r7_m23;
    logic          r7_x;
    logic [QW-1:0] r8_q;

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r7_m01 <= (w_quo[1] < w_quo[0]) ? w_quo[1] : w_quo[0];
            r7_m23 <= (w_quo[3] < w_quo[2]) ? w_quo[3] : w_quo[2];
            r7_x   <= r_xd[QW-1];
            if (r7_x) begin
                r8_q <= '0;
            end else begin
                r8_q <= (r7_m23 < r7_m01) ? r7_m23 : r7_m01;
            end
        end
    end

    // Square root of the smallest quotient
    logic [SW-1:0] w_root;

    s2sd_isqrt #(
        .COORD_BITS (COORD_BITS)
    ) u_isqrt (
        .i_clk  (i_clk),
        .i_ce   (w_ce),
        .i_val  (r8_q),
        .o_root (w_root)
    );

    // Add one and halve to round the root to the nearest integer, saturate into the output register
    logic [SW:0]          w_rp1;
    logic [SW+OUT_W-1:0]  w_ext;
    logic [OUT_W-1:0]     r_min_distance;

    assign w_rp1 = {1'b0, w_root} + (SW+1)'(1);
    assign w_ext = {{OUT_W{1'b0}}, w_rp1[SW:1]};

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_min_distance <= (w_ext[SW+OUT_W-1:OUT_W] != '0) ? '1 : w_ext[OUT_W-1:0];
        end
    end

    assign o_out_valid    = r_vld[LAT-1];
    assign o_min_distance = r_min_distance;

endmodule

FILE: src/s2sd_div.sv
// Pipelined restoring divider: one quotient bit per stage.
module s2sd_div #(
    parameter int COORD_BITS = s2sd_pkg::COORD_BITS_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_ce,
    input  logic [s2sd_pkg::f_den_w(COORD_BITS)
                  + s2sd_pkg::f_quo_w(COORD_BITS)-1:0] i_num,
    input  logic [s2sd_pkg::f_den_w(COORD_BITS)-1:0]   i_den,
    output logic [s2sd_pkg::f_quo_w(COORD_BITS)-1:0]   o_quo
);
    import s2sd_pkg::*;

    localparam int DEN_W = f_den_w(COORD_BITS);
    localparam int QUO_W = f_quo_w(COORD_BITS);
    localparam int NUM_W = DEN_W + QUO_W;

    // Stage registers: partial remainder, numerator bits merged with quotient bits
    logic [DEN_W-1:0] r_rem [QUO_W];
    logic [QUO_W-1:0] r_lo  [QUO_W];
    logic [DEN_W-1:0] r_den [QUO_W];

    genvar j;
    generate
        for (j = 0; j < QUO_W; j++) begin : g_stage
            logic [DEN_W-1:0] w_rem_in;
            logic [QUO_W-1:0] w_lo_in;
            logic [DEN_W-1:0] w_den_in;
            logic [DEN_W:0]   w_trial;
            logic [DEN_W+1:0] w_diff;
            logic             w_ge;

            // Take the upper numerator bits as the first remainder
            if (j == 0) begin : g_first
                assign w_rem_in = i_num[NUM_W-1:QUO_W];
                assign w_lo_in  = i_num[QUO_W-1:0];
                assign w_den_in = i_den;
            end else begin : g_next
                assign w_rem_in = r_rem[j-1];
                assign w_lo_in  = r_lo[j-1];
                assign w_den_in = r_den[j-1];
            end

            // Bring down one bit, subtract the divisor if it fits
            assign w_trial = {w_rem_in, w_lo_in[QUO_W-1]};
            assign w_diff  = {1'b0, w_trial} - {2'b00, w_den_in};
            assign w_ge    = ~w_diff[DEN_W+1];

            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    r_rem[j] <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
                    r_lo[j]  <= {w_lo_in[QUO_W-2:0], w_ge};
                    r_den[j] <= w_den_in;
                end
            end
        end
    endgenerate

    assign o_quo = r_lo[QUO_W-1];

endmodule

FILE: src/s2sd_isqrt.sv
// Pipelined integer square root: one root bit per stage.
module s2sd_isqrt #(
    parameter int COORD_BITS = s2sd_pkg::COORD_BITS_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_ce,
    input  logic [s2sd_pkg::f_quo_w(COORD_BITS)-1:0]  i_val,
    output logic [s2sd_pkg::f_sqrt_w(COORD_BITS)-1:0] o_root
);
    import s2sd_pkg::*;

    localparam int VAL_W = f_quo_w(COORD_BITS);
    localparam int SQ_W  = f_sqrt_w(COORD_BITS);
    localparam int REM_W = SQ_W + 2;

    logic [REM_W-1:0] r_rem  [SQ_W];
    logic [SQ_W-1:0]  r_root [SQ_W];
    logic [VAL_W-1:0] r_val  [SQ_W];

    genvar j;
    generate
        for (j = 0; j < SQ_W; j++) begin : g_stage
            logic [REM_W-1:0] w_rem_in;
            logic [SQ_W-1:0]  w_root_in;
            logic [VAL_W-1:0] w_val_in;
            logic [REM_W+1:0] w_r4;
            logic [REM_W+1:0] w_trial;
            logic [REM_W+2:0] w_diff;
            logic             w_ge;

            if (j == 0) begin : g_first
                assign w_rem_in  = '0;
                assign w_root_in = '0;
                assign w_val_in  = i_val;
            end else begin : g_next
                assign w_rem_in  = r_rem[j-1];
                assign w_root_in = r_root[j-1];
                assign w_val_in  = r_val[j-1];
            end

            // Bring down two bits, test against four times the root plus one
            assign w_r4    = {w_rem_in, w_val_in[VAL_W-1:VAL_W-2]};
            assign w_trial = {{(REM_W-SQ_W){1'b0}}, w_root_in, 2'b01};
            assign w_diff  = {1'b0, w_r4} - {1'b0, w_trial};
            assign w_ge    = ~w_diff[REM_W+2];

            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    r_rem[j]  <= w_ge ? w_diff[REM_W-1:0] : w_r4[REM_W-1:0];
                    r_root[j] <= {w_root_in[SQ_W-2:0], w_ge};
                    r_val[j]  <= {w_val_in[VAL_W-3:0], 2'b00};
                end
            end
        end
    endgenerate

    assign o_root = r_root[SQ_W-1];

endmodule
